// ===== rtl/awve_pkg.sv =====
// Shared types and constants for the adaptive window velocity estimator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package awve_pkg;

  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int POS_W = 32;
  localparam int VEL_W = 48;
  localparam int RATE_W = 20;
  localparam int BAND_W = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int FRAC_W = 16;

  // Weighted sum of up to WINDOW samples with weights of magnitude below WINDOW.
  localparam int SUM_W = POS_W + 2 * SLOT_W + 1;
  // Numerator |S| * 6 * 2^16 needs up to 19 more bits.
  localparam int NUM_W = SUM_W + 19;
  localparam int DIV_BITS = 4;
  localparam int QW = DIV_BITS * ((NUM_W + DIV_BITS - 1) / DIV_BITS);
  localparam int DIV_STEPS = QW / DIV_BITS;
  localparam int D_W = 3 * SLOT_W;
  localparam int DIFF_W = QW + SLOT_W + 2;
  localparam int PROD_W = QW + RATE_W;
  localparam int HI_W = QW - 32;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND = 1'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd100;
  localparam logic [BAND_W-1:0] BAND_RESET = 31'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_TEST,
    ST_ACCEPT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SAT,
    ST_DONE
  } lane_state_t;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic              ack;
  } lane_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

`default_nettype wire

// ===== rtl/awve_if.sv =====
// Valid/ready channel interfaces for position samples and velocity results.
// Depends on awve_pkg for the field widths.
`default_nettype none

interface awve_pos_if;
  logic                                valid;
  logic                                ready;
  logic signed [awve_pkg::POS_W-1:0]   pos_x;
  logic signed [awve_pkg::POS_W-1:0]   pos_y;
  logic signed [awve_pkg::POS_W-1:0]   pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface awve_vel_if;
  logic                                valid;
  logic                                ready;
  logic signed [awve_pkg::VEL_W-1:0]   vel_x;
  logic signed [awve_pkg::VEL_W-1:0]   vel_y;
  logic signed [awve_pkg::VEL_W-1:0]   vel_z;
  modport source (output valid, output vel_x, output vel_y, output vel_z, input ready);
  modport sink (input valid, input vel_x, input vel_y, input vel_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/awve_div.sv =====
// Iterative unsigned divider, DIV_BITS quotient bits per cycle.
// Depends on awve_pkg for widths.
`default_nettype none

module awve_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [awve_pkg::QW-1:0]    dividend,
  input  wire logic [awve_pkg::D_W-1:0]   divisor,
  output logic                            done,
  output logic [awve_pkg::QW-1:0]         quotient
);

  localparam int CNT_W = (awve_pkg::DIV_STEPS > 1) ? $clog2(awve_pkg::DIV_STEPS) : 1;

  logic [awve_pkg::D_W-1:0] rem;
  logic [awve_pkg::D_W-1:0] rem_next;
  logic [awve_pkg::QW-1:0]  quo;
  logic [awve_pkg::QW-1:0]  quo_next;
  logic [awve_pkg::D_W-1:0] dvs;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;

  always_comb begin
    logic [awve_pkg::D_W:0] t;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < awve_pkg::DIV_BITS; k++) begin
      t = {rem_next, quo_next[awve_pkg::QW-1]};
      quo_next = {quo_next[awve_pkg::QW-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = t[awve_pkg::D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(awve_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/awve_lane.sv =====
// One axis: sample store, growing-window slope fit, band test and velocity scaling.
// Depends on awve_pkg and awve_div.
`default_nettype none

module awve_lane (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire awve_pkg::lane_cmd_t                 cmd,
  input  wire logic signed [awve_pkg::POS_W-1:0]   sample,
  input  wire logic [awve_pkg::RATE_W-1:0]         rate,
  input  wire logic [awve_pkg::BAND_W-1:0]         band,
  output awve_pkg::lane_sts_t                      sts,
  output logic signed [awve_pkg::VEL_W-1:0]        vel
);

  localparam int SH_W = awve_pkg::PROD_W - awve_pkg::FRAC_W;
  localparam longint unsigned VEL_LIM = (64'd1 << (awve_pkg::VEL_W - 1)) - 64'd1;

  awve_pkg::lane_state_t state, state_next;

  logic signed [awve_pkg::POS_W-1:0]  store [awve_pkg::WINDOW];
  logic [awve_pkg::SLOT_W-1:0]        slot;
  logic [awve_pkg::SLOT_W-1:0]        i;
  logic [awve_pkg::SLOT_W-1:0]        l;
  logic [awve_pkg::SLOT_W-1:0]        j;
  logic signed [awve_pkg::POS_W-1:0]  y0;
  logic signed [awve_pkg::SUM_W-1:0]  acc;
  logic                               acc_neg;
  logic [awve_pkg::QW-1:0]            b_mag;
  logic                               b_neg;
  logic signed [awve_pkg::DIFF_W-1:0] b;
  logic signed [awve_pkg::DIFF_W-1:0] bj;
  logic [awve_pkg::QW-1:0]            kept_mag;
  logic                               kept_neg;
  logic [51:0]                        prod_lo;
  logic [awve_pkg::PROD_W-1:0]        prod;

  // Read side of the store: one address a cycle, l or j slots back from the newest slot.
  logic [awve_pkg::SLOT_W-1:0]        back;
  logic [awve_pkg::SLOT_W:0]          addr_raw;
  logic [awve_pkg::SLOT_W-1:0]        rd_idx;
  logic signed [awve_pkg::POS_W-1:0]  rd_y;

  assign back = (state == awve_pkg::ST_SUM) ? l : j;
  assign addr_raw = {1'b0, slot} + (awve_pkg::SLOT_W + 1)'(awve_pkg::WINDOW) - {1'b0, back};
  assign rd_idx = (addr_raw >= (awve_pkg::SLOT_W + 1)'(awve_pkg::WINDOW)) ?
                  awve_pkg::SLOT_W'(addr_raw - (awve_pkg::SLOT_W + 1)'(awve_pkg::WINDOW)) :
                  addr_raw[awve_pkg::SLOT_W-1:0];
  assign rd_y = store[rd_idx];

  // Weighted sum term (i - 2l) * y_l.
  logic signed [awve_pkg::SLOT_W+1:0] coef;
  logic signed [awve_pkg::SUM_W-1:0]  term;
  logic signed [awve_pkg::SUM_W-1:0]  acc_next;
  logic [awve_pkg::SUM_W-1:0]         acc_mag;
  logic [awve_pkg::QW-1:0]            num;
  logic [awve_pkg::D_W-1:0]           denom;
  logic [awve_pkg::D_W-1:0]           i_ext;

  assign coef = $signed({2'b00, i}) - $signed({1'b0, l, 1'b0});
  assign term = awve_pkg::SUM_W'(rd_y) * awve_pkg::SUM_W'(coef);
  assign acc_next = acc + term;
  assign acc_mag = acc_next[awve_pkg::SUM_W-1] ? awve_pkg::SUM_W'(-acc_next)
                                               : awve_pkg::SUM_W'(acc_next);
  // |S| * 6 * 2^16 as two shifted copies.
  assign num = (awve_pkg::QW'(acc_mag) << 18) + (awve_pkg::QW'(acc_mag) << 17);
  assign i_ext = awve_pkg::D_W'(i);
  assign denom = awve_pkg::D_W'(i_ext * (i_ext + 1'b1) * (i_ext + 2'd2));

  logic                  div_start;
  logic                  div_done;
  logic [awve_pkg::QW-1:0] div_q;

  awve_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (denom),
    .done     (div_done),
    .quotient (div_q)
  );

  // Deviation of sample j from the line drawn back from the newest sample.
  logic signed [awve_pkg::DIFF_W-1:0] ysub;
  logic signed [awve_pkg::DIFF_W-1:0] diff;
  logic signed [awve_pkg::DIFF_W-1:0] band_f;
  logic                               fail;

  assign ysub = awve_pkg::DIFF_W'(y0) - awve_pkg::DIFF_W'(rd_y);
  assign diff = (ysub <<< awve_pkg::FRAC_W) - bj;
  assign band_f = $signed(awve_pkg::DIFF_W'(band) << awve_pkg::FRAC_W);
  assign fail = (diff > band_f) || (diff < -band_f);

  logic [51:0]                            lo_p;
  logic [awve_pkg::HI_W+awve_pkg::RATE_W-1:0] hi_p;
  logic [SH_W-1:0]                        sh;
  logic [SH_W-1:0]                        sh_cap;
  logic signed [awve_pkg::VEL_W-1:0]      vel_next;

  assign lo_p = kept_mag[31:0] * rate;
  assign hi_p = kept_mag[awve_pkg::QW-1:32] * rate;
  assign sh = prod[awve_pkg::PROD_W-1:awve_pkg::FRAC_W];

  always_comb begin
    if (!kept_neg) begin
      sh_cap = (sh > SH_W'(VEL_LIM)) ? SH_W'(VEL_LIM) : sh;
      vel_next = awve_pkg::VEL_W'(sh_cap);
    end else begin
      sh_cap = (sh > SH_W'(VEL_LIM + 64'd1)) ? SH_W'(VEL_LIM + 64'd1) : sh;
      vel_next = awve_pkg::VEL_W'(0) - awve_pkg::VEL_W'(sh_cap);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      awve_pkg::ST_IDLE:   if (cmd.start) state_next = awve_pkg::ST_SUM;
      awve_pkg::ST_SUM:    if (l == i) state_next = awve_pkg::ST_DIV;
      awve_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (i == awve_pkg::SLOT_W'(1)) ? awve_pkg::ST_ACCEPT : awve_pkg::ST_TEST;
        end
      end
      awve_pkg::ST_TEST: begin
        if (fail) begin
          state_next = awve_pkg::ST_MUL_LO;
        end else if (j == i - 1'b1) begin
          state_next = awve_pkg::ST_ACCEPT;
        end
      end
      awve_pkg::ST_ACCEPT: begin
        state_next = (i == awve_pkg::SLOT_W'(awve_pkg::WINDOW - 1)) ?
                     awve_pkg::ST_MUL_LO : awve_pkg::ST_SUM;
      end
      awve_pkg::ST_MUL_LO: state_next = awve_pkg::ST_MUL_HI;
      awve_pkg::ST_MUL_HI: state_next = awve_pkg::ST_SAT;
      awve_pkg::ST_SAT:    state_next = awve_pkg::ST_DONE;
      awve_pkg::ST_DONE:   if (cmd.ack) state_next = awve_pkg::ST_IDLE;
      default:             state_next = awve_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    div_start = 1'b0;
    sts.idle  = 1'b0;
    sts.done  = 1'b0;
    case (state)
      awve_pkg::ST_IDLE: sts.idle = 1'b1;
      awve_pkg::ST_SUM:  div_start = (l == i);
      awve_pkg::ST_DONE: sts.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= awve_pkg::ST_IDLE;
      for (int k = 0; k < awve_pkg::WINDOW; k++) begin
        store[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == awve_pkg::ST_IDLE && cmd.start) begin
        store[cmd.slot] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      awve_pkg::ST_IDLE: begin
        if (cmd.start) begin
          slot     <= cmd.slot;
          y0       <= sample;
          i        <= awve_pkg::SLOT_W'(1);
          l        <= '0;
          acc      <= '0;
          kept_mag <= '0;
          kept_neg <= 1'b0;
        end
      end
      awve_pkg::ST_SUM: begin
        acc     <= acc_next;
        acc_neg <= acc_next[awve_pkg::SUM_W-1];
        l       <= l + 1'b1;
      end
      awve_pkg::ST_DIV: begin
        if (div_done) begin
          b_mag <= div_q;
          b_neg <= acc_neg;
          b     <= acc_neg ? -awve_pkg::DIFF_W'(div_q) : awve_pkg::DIFF_W'(div_q);
          bj    <= acc_neg ? -awve_pkg::DIFF_W'(div_q) : awve_pkg::DIFF_W'(div_q);
          j     <= awve_pkg::SLOT_W'(1);
        end
      end
      awve_pkg::ST_TEST: begin
        j  <= j + 1'b1;
        bj <= bj + b;
      end
      awve_pkg::ST_ACCEPT: begin
        kept_mag <= b_mag;
        kept_neg <= b_neg;
        i        <= i + 1'b1;
        l        <= '0;
        acc      <= '0;
      end
      awve_pkg::ST_MUL_LO: prod_lo <= lo_p;
      awve_pkg::ST_MUL_HI: begin
        prod <= awve_pkg::PROD_W'(prod_lo) + (awve_pkg::PROD_W'(hi_p) << 32);
      end
      awve_pkg::ST_SAT: vel <= vel_next;
      default: ;
    endcase
  end

  a_start_to_sum: assert property (@(posedge clk) disable iff (rst)
    (state == awve_pkg::ST_IDLE && cmd.start) |=> (state == awve_pkg::ST_SUM))
    else $error("lane did not begin summing after a start");

  a_sum_index: assert property (@(posedge clk) disable iff (rst)
    (state == awve_pkg::ST_SUM) |-> (l <= i && i != '0))
    else $error("sum index ran past the window length");

  a_test_index: assert property (@(posedge clk) disable iff (rst)
    (state == awve_pkg::ST_TEST) |-> (j != '0 && j < i))
    else $error("band test index out of range");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == awve_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

// ===== rtl/adaptive_window_velocity_estimator.sv =====
// Three-axis adaptive window velocity estimator. Each input beat carries one x, y, z
// position sample; one velocity beat follows for each. The three axes run in parallel
// lanes, each fitting slopes over windows of 2 to WINDOW samples in turn and stopping
// at the first window whose inner samples leave the band. The time taken between accepted
// samples is set in each lane by the per-window weighted sum and band test (one sample
// a cycle each) and by the iterative divide that follows each window's sum.
// A new sample is taken as soon as the lanes are idle, while the previous result may
// still sit in the output register. Configuration must be written only while idle.
`default_nettype none

module adaptive_window_velocity_estimator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [awve_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [awve_pkg::CFG_DATA_W-1:0]      cfg_data,
  awve_pos_if.sink                                  pos,
  awve_vel_if.source                                vel
);

  logic [awve_pkg::RATE_W-1:0]   sample_rate_hz;
  logic [awve_pkg::BAND_W-1:0]   band_halfwidth;
  logic [awve_pkg::SLOT_W-1:0]   write_slot;
  logic [awve_pkg::SLOT_W-1:0]   write_slot_next;
  logic                          out_valid;

  awve_pkg::lane_cmd_t           cmd;
  awve_pkg::lane_sts_t           sts [3];
  logic signed [awve_pkg::VEL_W-1:0] lane_vel [3];
  logic signed [awve_pkg::POS_W-1:0] lane_pos [3];

  logic all_idle;
  logic all_done;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz <= awve_pkg::RATE_RESET;
      band_halfwidth <= awve_pkg::BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        awve_pkg::REG_SAMPLE_RATE: sample_rate_hz <= cfg_data[awve_pkg::RATE_W-1:0];
        awve_pkg::REG_BAND:        band_halfwidth <= cfg_data[awve_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign all_idle = sts[0].idle & sts[1].idle & sts[2].idle;
  assign all_done = sts[0].done & sts[1].done & sts[2].done;
  assign pos.ready = all_idle;

  // The newest sample goes one slot on from the last.
  assign write_slot_next = (write_slot == awve_pkg::SLOT_W'(awve_pkg::WINDOW - 1)) ?
                           '0 : write_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (pos.valid && pos.ready) begin
      write_slot <= write_slot_next;
    end
  end

  assign take = all_done && (!out_valid || vel.ready);

  assign cmd.start = pos.valid & pos.ready;
  assign cmd.slot  = write_slot_next;
  assign cmd.ack   = take;

  assign lane_pos[0] = pos.pos_x;
  assign lane_pos[1] = pos.pos_y;
  assign lane_pos[2] = pos.pos_z;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    awve_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sample (lane_pos[a]),
      .rate   (sample_rate_hz),
      .band   (band_halfwidth),
      .sts    (sts[a]),
      .vel    (lane_vel[a])
    );
  end

  // Merge the three lane results into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (vel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vel.vel_x <= lane_vel[0];
      vel.vel_y <= lane_vel[1];
      vel.vel_z <= lane_vel[2];
    end
  end

  assign vel.valid = out_valid;

  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    (sts[0].idle == sts[1].idle) && (sts[1].idle == sts[2].idle))
    else $error("axis lanes fell out of step");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> all_idle)
    else $error("sample started while lanes busy");

  a_take_sets_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("merged result not presented");

endmodule

`default_nettype wire
